[rtl/core/edlc_pkg.sv]
package edlc_pkg;

    localparam int TAPE_DEPTH = 1024;
    localparam int NUM_VARS   = 64;

    localparam int IDX_W  = $clog2(TAPE_DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int OP_W   = 4;
    localparam int VAR_W  = 6;
    localparam int VI_W   = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int TAPE_W = OP_W + 2 * IDX_W;

    localparam logic [OP_W-1:0] OP_CONST = 4'd0;
    localparam logic [OP_W-1:0] OP_VAR   = 4'd1;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd2;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd4;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd5;
    localparam logic [OP_W-1:0] OP_NEG   = 4'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_OPND = 2'd2;
    localparam logic [1:0] ST_BAD_ROOT = 2'd3;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        OUT_APPEND = 3'd0,
        OUT_ABSENT = 3'd1,
        OUT_RANGE  = 3'd2,
        OUT_VAR    = 3'd3,
        OUT_NOVAR  = 3'd4
    } t_out_sel;

    typedef struct packed {
        logic     capture;
        logic     app_write;
        logic     idx_zero;
        logic     idx_inc;
        logic     idx_dec;
        logic     live_clr;
        logic     live_wr_left;
        logic     live_wr_right;
        logic     fl_sel_right;
        logic     latch_fl_left;
        logic     flag_wr;
        logic     used_clear;
        logic     vi_clear;
        logic     vi_inc;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic present;
        logic app_ok;
        logic root_bad;
        logic idx_is_zero;
        logic idx_is_root;
        logic used_empty;
        logic vi_bit;
        logic rest_zero;
        logic out_busy;
    } t_stat;

    function automatic logic [1:0] op_nargs(input logic [OP_W-1:0] op);
        if (op <= OP_VAR) begin
            return 2'd0;
        end else if (op <= OP_DIV) begin
            return 2'd2;
        end
        return 2'd1;
    endfunction

endpackage

[rtl/core/edlc_if.sv]
interface edlc_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [3:0] op_code;
    logic [9:0] left_index;
    logic [9:0] right_index;
    logic [5:0] var_index;
    logic [9:0] root_index;
    logic       root_present;

    modport source (output valid, mode, op_code, left_index, right_index, var_index,
                    root_index, root_present, input ready);
    modport sink   (input valid, mode, op_code, left_index, right_index, var_index,
                    root_index, root_present, output ready);
endinterface

interface edlc_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [1:0] status;
    logic [9:0] node_index;
    logic       is_linear;
    logic       has_var;
    logic [5:0] var_out;
    logic       last;

    modport source (output valid, result_kind, status, node_index, is_linear, has_var,
                    var_out, last, input ready);
    modport sink   (input valid, result_kind, status, node_index, is_linear, has_var,
                    var_out, last, output ready);
endinterface

[rtl/core/edlc_ram.sv]
module edlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/edlc_datapath.sv]
module edlc_datapath
    import edlc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic             i_mode,
    input  logic [OP_W-1:0]  i_op_code,
    input  logic [IDX_W-1:0] i_left_index,
    input  logic [IDX_W-1:0] i_right_index,
    input  logic [VAR_W-1:0] i_var_index,
    input  logic [IDX_W-1:0] i_root_index,
    input  logic             i_root_present,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_result_kind,
    output logic [1:0]       o_status,
    output logic [IDX_W-1:0] o_node_index,
    output logic             o_is_linear,
    output logic             o_has_var,
    output logic [VAR_W-1:0] o_var_out,
    output logic             o_last
);
    // latched request
    logic             r_mode;
    logic [OP_W-1:0]  r_op;
    logic [IDX_W-1:0] r_a;
    logic [IDX_W-1:0] r_b;
    logic [VAR_W-1:0] r_v;
    logic [IDX_W-1:0] r_root;
    logic             r_present;

    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_idx;
    logic [1:0]          r_fl_left;
    logic [NUM_VARS-1:0] r_used;
    logic [VI_W-1:0]     r_vi;
    logic                r_lin;

    logic                r_out_valid;
    logic                r_kind;
    logic [1:0]          r_status;
    logic [IDX_W-1:0]    r_node;
    logic                r_is_lin;
    logic                r_has_var;
    logic [VAR_W-1:0]    r_var_out;
    logic                r_last;

    logic [1:0]          app_n;
    logic                app_full;
    logic                app_bad;
    logic [1:0]          app_status;
    logic [IDX_W-1:0]    app_left;
    logic [TAPE_W-1:0]   tape_wdata;
    logic [TAPE_W-1:0]   tape_rdata;
    logic [OP_W-1:0]     t_op;
    logic [IDX_W-1:0]    t_l;
    logic [IDX_W-1:0]    t_r;
    logic [1:0]          t_n;
    logic                live_rdata;
    logic                live_we;
    logic [IDX_W-1:0]    live_waddr;
    logic                live_wdata;
    logic [1:0]          fl_rdata;
    logic [IDX_W-1:0]    fl_raddr;
    logic                va;
    logic                vb;
    logic                la;
    logic                lb;
    logic                hv;
    logic                ln;
    logic [NUM_VARS-1:0] used_rest;
    logic                var_in_range;

    // append checks
    always_comb begin
        app_n    = op_nargs(r_op);
        app_full = (r_count == CNT_W'(TAPE_DEPTH));
        app_bad  = ((app_n >= 2'd1) && ({1'b0, r_a} >= r_count))
                || ((app_n >= 2'd2) && ({1'b0, r_b} >= r_count));
        if (app_full) begin
            app_status = ST_FULL;
        end else if (app_bad) begin
            app_status = ST_BAD_OPND;
        end else begin
            app_status = ST_OK;
        end
        if (r_op == OP_VAR) begin
            app_left = IDX_W'(r_v);
        end else if (app_n >= 2'd1) begin
            app_left = r_a;
        end else begin
            app_left = '0;
        end
        tape_wdata = {r_op, app_left, (app_n >= 2'd2) ? r_b : IDX_W'(0)};
    end

    // a var node keeps its variable number in the left operand field
    assign t_op = tape_rdata[TAPE_W-1 -: OP_W];
    assign t_l  = tape_rdata[2*IDX_W-1 -: IDX_W];
    assign t_r  = tape_rdata[IDX_W-1:0];
    assign t_n  = op_nargs(t_op);

    edlc_ram #(.WIDTH(TAPE_W), .DEPTH(TAPE_DEPTH)) u_tape (
        .i_clk  (i_clk),
        .i_we   (i_cmd.app_write),
        .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(tape_wdata),
        .i_raddr(r_idx),
        .o_rdata(tape_rdata)
    );

    always_comb begin
        live_we    = i_cmd.live_clr
                  || (i_cmd.live_wr_left && live_rdata && (t_n >= 2'd1))
                  || (i_cmd.live_wr_right && live_rdata && (t_n >= 2'd2));
        live_waddr = i_cmd.live_clr ? r_idx : (i_cmd.live_wr_left ? t_l : t_r);
        // the clearing pass seeds the root on its final entry
        live_wdata = i_cmd.live_clr ? (r_idx == r_root) : 1'b1;
    end

    edlc_ram #(.WIDTH(1), .DEPTH(TAPE_DEPTH)) u_live (
        .i_clk  (i_clk),
        .i_we   (live_we),
        .i_waddr(live_waddr),
        .i_wdata(live_wdata),
        .i_raddr(r_idx),
        .o_rdata(live_rdata)
    );

    assign fl_raddr = i_cmd.fl_sel_right ? t_r : t_l;

    // classify the node at r_idx; flag word is {has_var, linear}
    always_comb begin
        va = (t_n >= 2'd1) && r_fl_left[1];
        vb = (t_n >= 2'd2) && fl_rdata[1];
        la = (t_n < 2'd1) || r_fl_left[0];
        lb = (t_n < 2'd2) || fl_rdata[0];
        case (t_op)
            OP_CONST: begin
                hv = 1'b0;
                ln = 1'b1;
            end
            OP_VAR: begin
                hv = 1'b1;
                ln = 1'b1;
            end
            OP_ADD, OP_SUB: begin
                hv = va || vb;
                ln = la && lb;
            end
            OP_MUL: begin
                hv = va || vb;
                ln = la && lb && !(va && vb);
            end
            OP_DIV: begin
                hv = va || vb;
                ln = la && !vb;
            end
            OP_NEG: begin
                hv = va;
                ln = la;
            end
            default: begin
                hv = va;
                ln = !va;
            end
        endcase
    end

    edlc_ram #(.WIDTH(2), .DEPTH(TAPE_DEPTH)) u_flags (
        .i_clk  (i_clk),
        .i_we   (i_cmd.flag_wr),
        .i_waddr(r_idx),
        .i_wdata({hv, ln}),
        .i_raddr(fl_raddr),
        .o_rdata(fl_rdata)
    );

    assign var_in_range = ({1'b0, t_l} < (IDX_W + 1)'(NUM_VARS));

    always_comb begin
        used_rest       = r_used;
        used_rest[r_vi] = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= i_mode;
            r_op      <= i_op_code;
            r_a       <= i_left_index;
            r_b       <= i_right_index;
            r_v       <= i_var_index;
            r_root    <= i_root_index;
            r_present <= i_root_present;
        end
        if (i_cmd.idx_zero) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.latch_fl_left) begin
            r_fl_left <= fl_rdata;
        end
        if (i_cmd.flag_wr && (r_idx == r_root)) begin
            r_lin <= ln;
        end
        if (i_cmd.vi_clear) begin
            r_vi <= '0;
        end else if (i_cmd.vi_inc) begin
            r_vi <= r_vi + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.app_write) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.used_clear) begin
                r_used <= '0;
            end else if (i_cmd.flag_wr && live_rdata && (t_op == OP_VAR) && var_in_range) begin
                r_used[t_l[VI_W-1:0]] <= 1'b1;
            end else if (i_cmd.out_load && (i_cmd.out_sel == OUT_VAR)) begin
                r_used[r_vi] <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_kind    <= 1'b1;
            r_status  <= ST_OK;
            r_node    <= '0;
            r_is_lin  <= r_lin;
            r_has_var <= 1'b0;
            r_var_out <= '0;
            r_last    <= 1'b1;
            case (i_cmd.out_sel)
                OUT_APPEND: begin
                    r_kind   <= 1'b0;
                    r_status <= app_status;
                    r_node   <= (app_status == ST_OK) ? r_count[IDX_W-1:0] : IDX_W'(0);
                    r_is_lin <= 1'b0;
                end
                OUT_ABSENT: begin
                    r_is_lin <= 1'b1;
                end
                OUT_RANGE: begin
                    r_status <= ST_BAD_ROOT;
                    r_is_lin <= 1'b0;
                end
                OUT_VAR: begin
                    r_has_var <= 1'b1;
                    r_var_out <= VAR_W'(r_vi);
                    r_last    <= (used_rest == '0);
                end
                default: begin
                    r_has_var <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.mode        = r_mode;
        o_stat.present     = r_present;
        o_stat.app_ok      = (app_status == ST_OK);
        o_stat.root_bad    = ({1'b0, r_root} >= r_count);
        o_stat.idx_is_zero = (r_idx == '0);
        o_stat.idx_is_root = (r_idx == r_root);
        o_stat.used_empty  = (r_used == '0);
        o_stat.vi_bit      = r_used[r_vi];
        o_stat.rest_zero   = (used_rest == '0);
        o_stat.out_busy    = r_out_valid && !i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_status      = r_status;
    assign o_node_index  = r_node;
    assign o_is_linear   = r_is_lin;
    assign o_has_var     = r_has_var;
    assign o_var_out     = r_var_out;
    assign o_last        = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TAPE_DEPTH))
        else $error("node count beyond tape depth");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.app_write |-> (r_count < CNT_W'(TAPE_DEPTH)))
        else $error("tape written while full");

    a_live_backward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.live_wr_left && live_rdata && (t_n >= 2'd1)) |-> (t_l < r_idx))
        else $error("live mark not below current node");

endmodule

[rtl/core/edlc_ctrl.sv]
module edlc_ctrl
    import edlc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_APP  = 12'b0000_0000_0010,
        S_QRY  = 12'b0000_0000_0100,
        S_CLR  = 12'b0000_0000_1000,
        S_BRD  = 12'b0000_0001_0000,
        S_BWL  = 12'b0000_0010_0000,
        S_BWR  = 12'b0000_0100_0000,
        S_FRD  = 12'b0000_1000_0000,
        S_FRL  = 12'b0001_0000_0000,
        S_FRR  = 12'b0010_0000_0000,
        S_FWR  = 12'b0100_0000_0000,
        S_EMIT = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_sel = OUT_APPEND;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_APP;
                end
            end
            S_APP: begin
                // mode is registered at capture and is known in this state
                if (i_stat.mode == MODE_QUERY) begin
                    n_state = S_QRY;
                end else if (!i_stat.out_busy) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.app_write = i_stat.app_ok;
                    n_state = S_IDLE;
                end
            end
            S_QRY: begin
                if (!i_stat.present) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OUT_ABSENT;
                        n_state = S_IDLE;
                    end
                end else if (i_stat.root_bad) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OUT_RANGE;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.used_clear = 1'b1;
                    o_cmd.idx_zero   = 1'b1;
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                o_cmd.live_clr = 1'b1;
                if (i_stat.idx_is_root) begin
                    n_state = S_BRD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_BRD: n_state = S_BWL;
            S_BWL: begin
                o_cmd.live_wr_left = 1'b1;
                n_state = S_BWR;
            end
            S_BWR: begin
                o_cmd.live_wr_right = 1'b1;
                if (i_stat.idx_is_zero) begin
                    n_state = S_FRD;
                end else begin
                    o_cmd.idx_dec = 1'b1;
                    n_state = S_BRD;
                end
            end
            S_FRD: n_state = S_FRL;
            S_FRL: n_state = S_FRR;
            S_FRR: begin
                o_cmd.fl_sel_right  = 1'b1;
                o_cmd.latch_fl_left = 1'b1;
                n_state = S_FWR;
            end
            S_FWR: begin
                o_cmd.flag_wr = 1'b1;
                if (i_stat.idx_is_root) begin
                    o_cmd.vi_clear = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_FRD;
                end
            end
            S_EMIT: begin
                if (i_stat.used_empty) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OUT_NOVAR;
                        n_state = S_IDLE;
                    end
                end else if (!i_stat.vi_bit) begin
                    o_cmd.vi_inc = 1'b1;
                end else if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_VAR;
                    o_cmd.vi_inc   = 1'b1;
                    if (i_stat.rest_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_stat.out_busy)
        else $error("result loaded over a waiting result");

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && (o_cmd.out_sel == OUT_VAR) && i_stat.rest_zero) |=>
        (r_state == S_IDLE))
        else $error("scan continued after final variable");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

endmodule

[rtl/core/expression_dag_linearity_check_core.sv]
// Channel   Dir  Modport            Carries
// i_in      in   edlc_in_if.sink    append node or root query request
// o_out     out  edlc_out_if.source append acknowledgement or query answers
//
// Append: the acknowledgement is loaded after accept, once the output register is free.
// Query: a live-flag clear over 0..root, a backward sweep from root down to 0,
// a forward sweep back up to root that reads the left and then the right flags
// through the one read port of the flag memory, then a scan of the 64 used bits.
// Reset clears the node count, the used-variable mask, the controller and the
// output valid only.
// A new request is taken once the block is back in idle, even while the last
// answer still waits in the output register; a stalled output holds the scan.
module expression_dag_linearity_check_core
    import edlc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    edlc_in_if.sink    i_in,
    edlc_out_if.source o_out
);
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // hand the request side to the controller
    assign i_in.ready = in_ready;

    edlc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(in_ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    // tape, flag memories, sweep index and output register
    edlc_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_in.mode),
        .i_op_code      (i_in.op_code),
        .i_left_index   (i_in.left_index),
        .i_right_index  (i_in.right_index),
        .i_var_index    (i_in.var_index),
        .i_root_index   (i_in.root_index),
        .i_root_present (i_in.root_present),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_result_kind  (o_out.result_kind),
        .o_status       (o_out.status),
        .o_node_index   (o_out.node_index),
        .o_is_linear    (o_out.is_linear),
        .o_has_var      (o_out.has_var),
        .o_var_out      (o_out.var_out),
        .o_last         (o_out.last)
    );

endmodule

[bench/expression_dag_linearity_check_core_tb.sv]
`timescale 1ns / 100ps

module expression_dag_linearity_check_core_tb;
    import edlc_pkg::*;

    typedef struct packed {
        logic       mode;
        logic [3:0] op_code;
        logic [9:0] left_index;
        logic [9:0] right_index;
        logic [5:0] var_index;
        logic [9:0] root_index;
        logic       root_present;
    } t_req;

    typedef struct packed {
        logic       result_kind;
        logic [1:0] status;
        logic [9:0] node_index;
        logic       is_linear;
        logic       has_var;
        logic [5:0] var_out;
        logic       last;
    } t_ans;

    localparam int STALL_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;

    edlc_in_if  in_ch ();
    edlc_out_if out_ch ();

    expression_dag_linearity_check_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Predictor state: a shadow of the tape and its node count.
    logic [3:0] sh_op    [TAPE_DEPTH];
    logic [9:0] sh_left  [TAPE_DEPTH];
    logic [9:0] sh_right [TAPE_DEPTH];
    logic [5:0] sh_var   [TAPE_DEPTH];
    int         sh_count;

    t_req pending_reqs[$];
    t_ans answers_due[$];
    int   errors;
    int   idle_cycles;
    int   hold_off;     // cycles the receiver still holds off
    int   send_gap;
    logic stim_done;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    function automatic int arg_count(logic [3:0] op);
        if (op <= OP_VAR) return 0;
        if (op <= OP_DIV) return 2;
        return 1;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(0, 3);
    endfunction

    task automatic push_ans(logic kind, logic [1:0] st, logic [9:0] node, logic lin,
                            logic hv, logic [5:0] v, logic lst);
        t_ans a;
        a = '{kind, st, node, lin, hv, v, lst};
        answers_due.insert(answers_due.size(), a);
    endtask

    // Predict the answers of one accepted request and advance the shadow tape.
    task automatic predict_linearity(t_req r);
        bit   live [TAPE_DEPTH];
        bit   hvf  [TAPE_DEPTH];
        bit   lnf  [TAPE_DEPTH];
        logic [63:0] used;
        int   n;
        int   root;
        bit   va, vb, la, lb, hv, ln, lin;
        int   emitted;
        if (r.mode == MODE_APPEND) begin
            n = arg_count(r.op_code);
            if (sh_count >= TAPE_DEPTH) begin
                push_ans(1'b0, ST_FULL, '0, 1'b0, 1'b0, '0, 1'b1);
            end else if ((n >= 1 && r.left_index >= sh_count) ||
                         (n >= 2 && r.right_index >= sh_count)) begin
                push_ans(1'b0, ST_BAD_OPND, '0, 1'b0, 1'b0, '0, 1'b1);
            end else begin
                sh_op[sh_count]    = r.op_code;
                sh_left[sh_count]  = (n >= 1) ? r.left_index : '0;
                sh_right[sh_count] = (n >= 2) ? r.right_index : '0;
                sh_var[sh_count]   = r.var_index;
                push_ans(1'b0, ST_OK, 10'(sh_count), 1'b0, 1'b0, '0, 1'b1);
                sh_count++;
            end
            return;
        end
        if (!r.root_present) begin
            push_ans(1'b1, ST_OK, '0, 1'b1, 1'b0, '0, 1'b1);
            return;
        end
        root = r.root_index;
        if (root >= sh_count) begin
            push_ans(1'b1, ST_BAD_ROOT, '0, 1'b0, 1'b0, '0, 1'b1);
            return;
        end
        for (int i = 0; i <= root; i++) live[i] = 0;
        live[root] = 1;
        for (int i = root; i >= 0; i--) begin
            if (live[i]) begin
                n = arg_count(sh_op[i]);
                if (n >= 1) live[sh_left[i]] = 1;
                if (n >= 2) live[sh_right[i]] = 1;
            end
        end
        used = '0;
        for (int i = 0; i <= root; i++) begin
            if (live[i]) begin
                n  = arg_count(sh_op[i]);
                va = n >= 1 && hvf[sh_left[i]];
                vb = n >= 2 && hvf[sh_right[i]];
                la = n < 1 || lnf[sh_left[i]];
                lb = n < 2 || lnf[sh_right[i]];
                case (sh_op[i])
                    OP_CONST: begin hv = 0; ln = 1; end
                    OP_VAR: begin
                        hv = 1; ln = 1;
                        used[sh_var[i]] = 1'b1;
                    end
                    OP_ADD, OP_SUB: begin hv = va || vb; ln = la && lb; end
                    OP_MUL: begin hv = va || vb; ln = la && lb && !(va && vb); end
                    OP_DIV: begin hv = va || vb; ln = la && !vb; end
                    OP_NEG: begin hv = va; ln = la; end
                    default: begin hv = va; ln = !va; end
                endcase
                hvf[i] = hv;
                lnf[i] = ln;
            end
        end
        lin = lnf[root];
        emitted = 0;
        for (int i = 0; i < NUM_VARS; i++) begin
            if (used[i]) begin
                push_ans(1'b1, ST_OK, '0, lin, 1'b1, 6'(i),
                         (i == 63 || (used >> (i + 1)) == 0) ? 1'b1 : 1'b0);
                emitted++;
            end
        end
        if (emitted == 0) push_ans(1'b1, ST_OK, '0, lin, 1'b0, '0, 1'b1);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // Stimulus builders. A model count tracks tape growth for legal operands.
    int model_count;

    task automatic add_node(logic [3:0] op, int a, int b, int v);
        t_req r;
        r = '{MODE_APPEND, op, 10'(a), 10'(b), 6'(v), 10'($urandom), 1'($urandom)};
        pending_reqs.insert(pending_reqs.size(), r);
        if (model_count < TAPE_DEPTH &&
            !((arg_count(op) >= 1 && a >= model_count) ||
              (arg_count(op) >= 2 && b >= model_count)))
            model_count++;
    endtask

    task automatic add_query(int root, bit present);
        t_req r;
        r = '{MODE_QUERY, 4'($urandom), 10'($urandom), 10'($urandom), 6'($urandom),
              10'(root), present};
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    function automatic int earlier();
        if (model_count == 0) return 0;
        if ($urandom_range(0, 2) == 0) return model_count - 1;
        return $urandom_range(0, model_count - 1);
    endfunction

    initial begin
        int root;
        int opsel;
        errors      = 0;
        sh_count    = 0;
        model_count = 0;
        stim_done   = 1'b0;
        // Directed part: empty tape cases, every op, var extremes, bad operands.
        add_query(0, 0);
        add_query(0, 1);
        add_node(OP_ADD, 0, 0, 0);
        add_node(OP_VAR, 1023, 1023, 63);
        add_node(OP_VAR, 0, 0, 0);
        add_node(OP_CONST, 1023, 1023, 17);
        add_node(OP_MUL, 0, 1, 0);
        add_node(OP_MUL, 0, 2, 0);
        add_node(OP_DIV, 0, 2, 0);
        add_node(OP_DIV, 2, 0, 0);
        add_node(OP_SUB, 4, 5, 0);
        add_node(OP_NEG, 8, 1023, 0);
        for (int op = 7; op <= 15; op++) add_node(4'(op), (op & 1) ? 0 : 2, 0, 0);
        add_node(OP_ADD, 0, 1023, 0);
        add_node(OP_ADD, 1023, 0, 0);
        add_query(model_count - 1, 1);
        add_query(9, 1);
        add_query(1023, 1);
        // Random part: mostly legal appends, queries over growing trees.
        for (int k = 0; k < 140; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                root = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : earlier();
                add_query(root, $urandom_range(0, 9) != 0);
            end else if ($urandom_range(0, 11) == 0) begin
                add_node(4'($urandom), $urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom);
            end else begin
                opsel = $urandom_range(0, 3) == 0 ? OP_VAR : $urandom_range(0, 15);
                add_node(4'(opsel), earlier(), earlier(),
                         $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom);
            end
        end
        add_query(model_count - 1, 1);
        stim_done = 1'b1;
    end

    // Driver: one request at a time from the pending queue, random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap    <= 0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold the offered request
        end else if (send_gap > 0) begin
            in_ch.valid <= 1'b0;
            send_gap    <= send_gap - 1;
        end else if (pending_reqs.size() > 0) begin
            t_req r;
            r = pending_reqs.pop_front();
            in_ch.valid        <= 1'b1;
            in_ch.mode         <= r.mode;
            in_ch.op_code      <= r.op_code;
            in_ch.left_index   <= r.left_index;
            in_ch.right_index  <= r.right_index;
            in_ch.var_index    <= r.var_index;
            in_ch.root_index   <= r.root_index;
            in_ch.root_present <= r.root_present;
            send_gap           <= pick_gap();
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Predict on accept, at the same edge the block takes the request.
    always @(posedge i_clk) begin
        t_req r;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            r = '{in_ch.mode, in_ch.op_code, in_ch.left_index, in_ch.right_index,
                  in_ch.var_index, in_ch.root_index, in_ch.root_present};
            predict_linearity(r);
        end
    end

    // Receiver: random stalls, plus one long hold-off early in the run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_off     <= 400;
        end else if (hold_off > 0) begin
            out_ch.ready <= 1'b0;
            hold_off     <= hold_off - 1;
        end else if (out_ch.valid && out_ch.ready) begin
            out_ch.ready <= 1'b0;
            hold_off     <= pick_gap();
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Monitor: compare every accepted answer with the oldest prediction.
    always @(posedge i_clk) begin
        t_ans w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected answer", 1, 0);
            end else begin
                w = answers_due.pop_front();
                if (out_ch.result_kind !== w.result_kind)
                    report_mismatch("result_kind", out_ch.result_kind, w.result_kind);
                if (out_ch.status !== w.status)
                    report_mismatch("status", out_ch.status, w.status);
                if (out_ch.node_index !== w.node_index)
                    report_mismatch("node_index", out_ch.node_index, w.node_index);
                if (out_ch.is_linear !== w.is_linear)
                    report_mismatch("is_linear", out_ch.is_linear, w.is_linear);
                if (out_ch.has_var !== w.has_var)
                    report_mismatch("has_var", out_ch.has_var, w.has_var);
                if (out_ch.var_out !== w.var_out)
                    report_mismatch("var_out", out_ch.var_out, w.var_out);
                if (out_ch.last !== w.last)
                    report_mismatch("last", out_ch.last, w.last);
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = 1'b0;
        in_ch.op_code      = '0;
        in_ch.left_index   = '0;
        in_ch.right_index  = '0;
        in_ch.var_index    = '0;
        in_ch.root_index   = '0;
        in_ch.root_present = 1'b0;
        out_ch.ready       = 1'b0;
        idle_cycles        = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            begin
                wait (stim_done);
                while (pending_reqs.size() > 0 || in_ch.valid || answers_due.size() > 0)
                    @(posedge i_clk);
                repeat (100) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= STALL_LIMIT);
            end
        join_any
        if (idle_cycles < STALL_LIMIT && errors == 0 && answers_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            if (answers_due.size() > 0) $display("%0d answers missing", answers_due.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/edlc_pkg.sv
rtl/core/edlc_if.sv
rtl/core/edlc_ram.sv
rtl/core/edlc_datapath.sv
rtl/core/edlc_ctrl.sv
rtl/core/expression_dag_linearity_check_core.sv
bench/expression_dag_linearity_check_core_tb.sv
